// ===== sv/ir_slope_activation_detector_macros.svh =====
// ----------------------------------------------------------------------------
// ir_slope_activation_detector assertion macros
// shared assertion shorthands, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef IR_SLOPE_ACTIVATION_DETECTOR_MACROS_SVH
`define IR_SLOPE_ACTIVATION_DETECTOR_MACROS_SVH

// same-cycle implication
`define ISAD_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ISAD_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/isad_pkg.sv =====
// ----------------------------------------------------------------------------
// isad_pkg
// widths, codes and the cutoff table of the slope activation detector
// ----------------------------------------------------------------------------
`default_nettype none

package isad_pkg;

    localparam int SENS_W   = 2;
    localparam int CHAN_W   = 3;
    localparam int READ_W   = 13;
    localparam int SLOPE_W  = 14;
    localparam int STR_W    = 8;
    localparam int DIR_W    = 2;
    localparam int QUIET_W  = 6;
    localparam int RING_W   = 3;
    localparam int SUM4_W   = 16;
    localparam int SUM8_W   = 17;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int CUT_W    = 7;

    localparam logic [SENS_W-1:0]  SENS_RESET   = 2'd2;
    localparam logic [QUIET_W-1:0] QUIET_LIMIT  = 6'd50;
    localparam logic [QUIET_W-1:0] QUIET_MAX    = 6'd63;
    localparam logic [STR_W-1:0]   STRENGTH_MAX = 8'd255;

    // register index, taken from paddr[2]
    localparam logic REG_SENSITIVITY = 1'b0;

    typedef enum logic [DIR_W-1:0] {
        DIR_NONE    = 2'd0,
        DIR_FALLING = 2'd1,
        DIR_RISING  = 2'd2
    } dir_t;

    function automatic logic [CUT_W-1:0] cutoff_of(input logic [SENS_W-1:0] sens);
        logic [CUT_W-1:0] c;
        unique case (sens)
            2'd0:    c = 7'd100;
            2'd1:    c = 7'd50;
            2'd2:    c = 7'd35;
            default: c = 7'd20;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/isad_in_if.sv =====
// ----------------------------------------------------------------------------
// isad_in_if
// request channel carrying one channel number and one proximity reading
// ----------------------------------------------------------------------------
`default_nettype none

interface isad_in_if;
    import isad_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] channel;
    logic [READ_W-1:0] reading;

    modport source (output valid, output channel, output reading, input ready);
    modport sink   (input valid, input channel, input reading, output ready);
endinterface

`default_nettype wire

// ===== sv/isad_out_if.sv =====
// ----------------------------------------------------------------------------
// isad_out_if
// result channel carrying strength, direction and filtered slope
// ----------------------------------------------------------------------------
`default_nettype none

interface isad_out_if;
    import isad_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STR_W-1:0]          strength;
    logic [DIR_W-1:0]          direction;
    logic signed [SLOPE_W-1:0] filtered_slope;

    modport source (output valid, output strength, output direction,
                    output filtered_slope, input ready);
    modport sink   (input valid, input strength, input direction,
                    input filtered_slope, output ready);
endinterface

`default_nettype wire

// ===== sv/isad_ram.sv =====
// ----------------------------------------------------------------------------
// isad_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module isad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/ir_slope_activation_detector.sv =====
// ----------------------------------------------------------------------------
// ir_slope_activation_detector
// per-channel slope trigger for proximity readings
// ----------------------------------------------------------------------------
// Each request brings a channel number and a reading. Per channel the block
// compares the new reading with the one taken HISTORY_DEPTH-1 readings earlier,
// averages the last eight or four such slopes and raises a trigger strength
// when the averaged magnitude reaches the cutoff picked by sensitivity. One
// request is taken every clock unless the result side stalls; its result
// passes stage 1 into the output register. The rate is set by the two memory
// read ports (reading history, slope ring), read at acceptance and written
// back as the request leaves stage 1; a same-address collision is bypassed.
// No clearing pass follows reset: readings not yet written count as zero
// through a per-channel fill flag, slope entries through one valid bit each.
// The sensitivity register should only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ir_slope_activation_detector_macros.svh"

module ir_slope_activation_detector #(
    parameter int CHANNELS      = 8,
    parameter int HISTORY_DEPTH = 14
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // apb configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [isad_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [isad_pkg::PDATA_W-1:0]  pwdata,
    output logic      [isad_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    // streams
    isad_in_if.sink                            sample,
    isad_out_if.source                         result
);
    import isad_pkg::*;

    // ------------------------------------------------------------------------
    // sizes
    // ------------------------------------------------------------------------
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HRING       = HISTORY_DEPTH - 1;     // readings kept back
    localparam int HP_W        = (HRING > 1) ? $clog2(HRING) : 1;
    localparam int HA_W        = CH_W + HP_W;
    localparam int HMEM_DEPTH  = 1 << HA_W;
    localparam int RA_W        = CH_W + RING_W;
    localparam int RMEM_DEPTH  = 1 << RA_W;
    localparam logic [HP_W-1:0] HPTR_LAST = HP_W'(HRING - 1);

    // ------------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------------
    logic [SENS_W-1:0] sens_reg;
    logic              cfg_wr;
    logic              len8;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg <= SENS_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_SENSITIVITY))
        begin
            sens_reg <= pwdata[SENS_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SENSITIVITY) ? PDATA_W'(sens_reg) : '0;

    // sensitivity 0 and 1 average eight slopes, 2 and 3 average four
    assign len8 = !sens_reg[1];

    // ------------------------------------------------------------------------
    // handshake and stage control
    // ------------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s1_adv;
    logic acc;

    assign s1_adv       = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || s1_adv;
    assign acc          = sample.valid && sample.ready;

    // ------------------------------------------------------------------------
    // accept side: address generation and per-channel pointers
    // ------------------------------------------------------------------------
    logic              in_range_in;
    logic [CH_W-1:0]   ch_in;
    logic [HP_W-1:0]   hptr_in;
    logic [RING_W-1:0] slot_in;
    logic [HA_W-1:0]   hist_raddr;
    logic [RA_W-1:0]   ring_raddr;

    logic [HP_W-1:0]   hptr_reg  [CHANNELS];
    logic [CHANNELS-1:0] hfull_reg;          // history ring has wrapped once
    logic [RING_W-1:0] rpos_reg  [CHANNELS];
    logic [RMEM_DEPTH-1:0] rvalid_reg;       // slope entry written since reset

    // out-of-range channels touch no state; park them on channel zero
    assign in_range_in = (32'(sample.channel) < 32'(CHANNELS));
    assign ch_in       = in_range_in ? CH_W'(sample.channel) : '0;
    assign hptr_in     = hptr_reg[ch_in];
    assign slot_in     = len8 ? rpos_reg[ch_in] : {1'b0, rpos_reg[ch_in][1:0]};
    assign hist_raddr  = {ch_in, hptr_in};
    assign ring_raddr  = {ch_in, slot_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                hptr_reg[c] <= '0;
                rpos_reg[c] <= '0;
            end
            hfull_reg <= '0;
        end
        else if (acc && in_range_in)
        begin
            if (hptr_in == HPTR_LAST)
            begin
                hptr_reg[ch_in]  <= '0;
                hfull_reg[ch_in] <= 1'b1;
            end
            else
            begin
                hptr_reg[ch_in] <= hptr_in + 1'b1;
            end
            rpos_reg[ch_in] <= rpos_reg[ch_in] + 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // stage 1 registers (memory read data arrives alongside)
    // ------------------------------------------------------------------------
    logic [CH_W-1:0]           s1_ch_reg;
    logic                      s1_in_range_reg;
    logic [READ_W-1:0]         s1_reading_reg;
    logic [HP_W-1:0]           s1_hptr_reg;
    logic [RING_W-1:0]         s1_slot_reg;
    logic                      s1_hvalid_reg;
    logic                      s1_rvalid_reg;
    logic                      s1_hfwd_reg;
    logic [READ_W-1:0]         s1_hfwd_data_reg;
    logic                      s1_rfwd_reg;
    logic signed [SLOPE_W-1:0] s1_rfwd_data_reg;

    logic                      s1_wr;
    logic [HA_W-1:0]           hist_waddr;
    logic [RA_W-1:0]           ring_waddr;
    logic [READ_W-1:0]         hist_rdata;
    logic [SLOPE_W-1:0]        ring_rdata;
    logic signed [SLOPE_W-1:0] slope_s1;

    assign s1_wr      = s1_adv && s1_in_range_reg;
    assign hist_waddr = {s1_ch_reg, s1_hptr_reg};
    assign ring_waddr = {s1_ch_reg, s1_slot_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_ch_reg        <= ch_in;
            s1_in_range_reg  <= in_range_in;
            s1_reading_reg   <= sample.reading;
            s1_hptr_reg      <= hptr_in;
            s1_slot_reg      <= slot_in;
            s1_hvalid_reg    <= hfull_reg[ch_in];
            s1_rvalid_reg    <= rvalid_reg[ring_raddr];
            // bypass a write-back landing on the address being read
            s1_hfwd_reg      <= s1_wr && (hist_waddr == hist_raddr);
            s1_hfwd_data_reg <= s1_reading_reg;
            s1_rfwd_reg      <= s1_wr && (ring_waddr == ring_raddr);
            s1_rfwd_data_reg <= slope_s1;
        end
    end

    isad_ram #(
        .WIDTH (READ_W),
        .DEPTH (HMEM_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (s1_wr),
        .waddr (hist_waddr),
        .wdata (s1_reading_reg),
        .re    (acc),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    isad_ram #(
        .WIDTH (SLOPE_W),
        .DEPTH (RMEM_DEPTH)
    ) u_ring_ram (
        .clk   (clk),
        .we    (s1_wr),
        .waddr (ring_waddr),
        .wdata (slope_s1),
        .re    (acc),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= '0;
        end
        else if (s1_wr)
        begin
            rvalid_reg[ring_waddr] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // stage 1 datapath: slope, running sums, filter, trigger decision
    // ------------------------------------------------------------------------
    logic signed [SUM4_W-1:0]  sum4_reg  [CHANNELS];   // ring entries 0..3
    logic signed [SUM8_W-1:0]  sum8_reg  [CHANNELS];   // ring entries 0..7
    dir_t                      mode_reg  [CHANNELS];
    logic [QUIET_W-1:0]        quiet_reg [CHANNELS];

    logic [READ_W-1:0]         oldest;
    logic signed [SLOPE_W-1:0] old_slope;
    logic signed [SLOPE_W:0]   delta;
    logic signed [SUM4_W-1:0]  sum4_next;
    logic signed [SUM8_W-1:0]  sum8_next;
    logic signed [SUM8_W-1:0]  sum_sel;
    logic signed [SUM8_W-1:0]  filt_wide;
    logic signed [SLOPE_W-1:0] filt;
    logic                      neg;
    logic                      pos;
    logic [SLOPE_W-1:0]        mag;
    dir_t                      mode_eff;
    logic                      suppressed;
    logic                      trig;
    logic [STR_W-1:0]          strength_s1;
    dir_t                      dir_s1;
    logic [QUIET_W-1:0]        quiet_cur;

    always_comb
    begin
        // reading from HISTORY_DEPTH-1 requests ago, zero until the ring fills
        if (s1_hfwd_reg)
        begin
            oldest = s1_hfwd_data_reg;
        end
        else if (s1_hvalid_reg)
        begin
            oldest = hist_rdata;
        end
        else
        begin
            oldest = '0;
        end

        if (s1_rfwd_reg)
        begin
            old_slope = s1_rfwd_data_reg;
        end
        else if (s1_rvalid_reg)
        begin
            old_slope = $signed(ring_rdata);
        end
        else
        begin
            old_slope = '0;
        end
    end

    assign slope_s1 = $signed({1'b0, s1_reading_reg}) - $signed({1'b0, oldest});
    assign delta    = $signed({slope_s1[SLOPE_W-1], slope_s1})
                    - $signed({old_slope[SLOPE_W-1], old_slope});

    // incremental sums: drop the overwritten entry, add the new slope
    assign sum8_next = sum8_reg[s1_ch_reg]
                     + $signed({{(SUM8_W-SLOPE_W-1){delta[SLOPE_W]}}, delta});
    assign sum4_next = s1_slot_reg[RING_W-1] ? sum4_reg[s1_ch_reg]
                     : sum4_reg[s1_ch_reg]
                       + $signed({{(SUM4_W-SLOPE_W-1){delta[SLOPE_W]}}, delta});

    assign sum_sel   = len8 ? sum8_next : $signed({sum4_next[SUM4_W-1], sum4_next});
    // arithmetic shift is floor division
    assign filt_wide = len8 ? (sum_sel >>> 3) : (sum_sel >>> 2);
    assign filt      = $signed(filt_wide[SLOPE_W-1:0]);

    assign neg       = filt[SLOPE_W-1];
    assign pos       = !neg && (filt != '0);
    assign mag       = neg ? (SLOPE_W'(0) - filt) : filt;

    // quiet release clears the direction lock before the check
    assign quiet_cur = quiet_reg[s1_ch_reg];
    assign mode_eff  = (quiet_cur > QUIET_LIMIT) ? DIR_NONE : mode_reg[s1_ch_reg];

    assign suppressed = ((mode_eff == DIR_RISING) && neg)
                     || ((mode_eff == DIR_FALLING) && pos);
    assign trig       = !suppressed && (mag >= SLOPE_W'(cutoff_of(sens_reg)));

    always_comb
    begin
        strength_s1 = '0;
        dir_s1      = DIR_NONE;
        if (trig)
        begin
            strength_s1 = (mag[SLOPE_W-1:STR_W] != '0) ? STRENGTH_MAX : mag[STR_W-1:0];
            dir_s1      = neg ? DIR_FALLING : DIR_RISING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum4_reg[c]  <= '0;
                sum8_reg[c]  <= '0;
                mode_reg[c]  <= DIR_NONE;
                quiet_reg[c] <= '0;
            end
        end
        else if (s1_wr)
        begin
            sum4_reg[s1_ch_reg] <= sum4_next;
            sum8_reg[s1_ch_reg] <= sum8_next;
            if (trig)
            begin
                mode_reg[s1_ch_reg]  <= dir_s1;
                quiet_reg[s1_ch_reg] <= '0;
            end
            else
            begin
                mode_reg[s1_ch_reg] <= mode_eff;
                if (quiet_cur != QUIET_MAX)
                begin
                    quiet_reg[s1_ch_reg] <= quiet_cur + 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------------
    logic [STR_W-1:0]          out_strength_reg;
    dir_t                      out_dir_reg;
    logic signed [SLOPE_W-1:0] out_filt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // out-of-range channels report all zero
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_strength_reg <= s1_in_range_reg ? strength_s1 : '0;
            out_dir_reg      <= s1_in_range_reg ? dir_s1 : DIR_NONE;
            out_filt_reg     <= s1_in_range_reg ? filt : '0;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.strength       = out_strength_reg;
    assign result.direction      = out_dir_reg;
    assign result.filtered_slope = out_filt_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `ISAD_ASSERT_IMP(a_dir_matches_strength, result.valid,
        (result.strength != '0) == (result.direction != DIR_NONE),
        "direction and strength disagree on trigger")
    `ISAD_ASSERT_IMP(a_rising_not_negative, result.valid && (result.direction == DIR_RISING),
        !result.filtered_slope[SLOPE_W-1],
        "rising trigger reported with negative filtered slope")
    `ISAD_ASSERT_IMP(a_stall_only_when_full, !sample.ready,
        s1_valid_reg && out_valid_reg && !result.ready,
        "request side stalled while the pipeline can move")
    `ISAD_ASSERT_NXT(a_trigger_resets_quiet, s1_wr && trig,
        quiet_reg[$past(s1_ch_reg)] == '0,
        "quiet count not cleared after a trigger")

endmodule

`default_nettype wire

// ===== verif/ir_slope_activation_detector_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_slope_activation_detector_tb
// self-checking bench for the per-channel slope trigger
// ----------------------------------------------------------------------------
// Drives channel/reading requests with random gaps against a result sink with
// random stalls. A scoreboard keeps its own copy of every channel's history,
// slope ring, trigger mode and quiet count, predicts strength, direction and
// filtered slope per request and checks results in order. Sensitivity is
// rewritten over apb between phases, only once all results are back.
// ----------------------------------------------------------------------------

module ir_slope_activation_detector_tb;
    import isad_pkg::*;

    localparam int CHANNELS      = 8;
    localparam int HISTORY_DEPTH = 14;
    localparam int RING_SLOTS    = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 270;
    localparam int READ_MAX      = 8191;

    // sensitivity register sits at index 0, the index is paddr[2]
    localparam logic [PADDR_W-1:0] SENS_ADDR = {REG_SENSITIVITY, 2'b00};

    typedef struct packed {
        logic [STR_W-1:0]   strength;
        dir_t               direction;
        logic [SLOPE_W-1:0] filtered_slope;
    } trigger_t;

    // ------------------------------------------------------------------------
    // scoreboard: per-channel prediction plus an in-order queue of results
    // ------------------------------------------------------------------------
    class slope_scoreboard;
        int unsigned               mismatches;
        int                        cutoff_tbl[4];
        logic [SENS_W-1:0]         sens;
        logic [READ_W-1:0]         history [CHANNELS][HISTORY_DEPTH];
        logic signed [SLOPE_W-1:0] ring [CHANNELS][RING_SLOTS];
        logic [RING_W-1:0]         ring_pos [CHANNELS];
        dir_t                      mode [CHANNELS];
        logic [QUIET_W-1:0]        quiet [CHANNELS];
        trigger_t                  expected_q[$];

        function new();
            mismatches = 0;
            cutoff_tbl = '{100, 50, 35, 20};
            sens = 2'd2;
            foreach (history[c, i]) history[c][i] = '0;
            foreach (ring[c, i]) ring[c][i] = '0;
            foreach (ring_pos[c])
            begin
                ring_pos[c] = '0;
                mode[c]     = DIR_NONE;
                quiet[c]    = '0;
            end
        endfunction

        function void set_sensitivity(logic [SENS_W-1:0] value);
            sens = value;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // advance one channel by one reading and queue the result it yields
        function void note_request(logic [CHAN_W-1:0] ch, logic [READ_W-1:0] rd);
            trigger_t t;
            int       i;
            int       slope;
            int       sum;
            int       filt;
            int       mag;
            int       len;
            int       slot;
            t.strength       = '0;
            t.direction      = DIR_NONE;
            t.filtered_slope = '0;
            if (int'(ch) < CHANNELS)
            begin
                for (i = 0; i < HISTORY_DEPTH - 1; i++)
                    history[ch][i] = history[ch][i + 1];
                history[ch][HISTORY_DEPTH - 1] = rd;
                slope = int'(rd) - int'(history[ch][0]);

                // averaging over eight slots for the two low settings, else four
                len  = (sens <= 2'd1) ? 8 : 4;
                slot = int'(ring_pos[ch]) & (len - 1);
                ring_pos[ch] = ring_pos[ch] + 1'b1;
                ring[ch][slot] = slope[SLOPE_W-1:0];
                sum = 0;
                for (i = 0; i < len; i++)
                    sum += ring[ch][i];
                filt = sum >>> ((len == 8) ? 3 : 2);

                if (quiet[ch] > QUIET_LIMIT)
                    mode[ch] = DIR_NONE;
                mag = (filt < 0) ? -filt : filt;
                if (!(mode[ch] == DIR_RISING && filt < 0) &&
                    !(mode[ch] == DIR_FALLING && filt > 0) &&
                    mag >= cutoff_tbl[sens])
                begin
                    t.strength  = (mag > 255) ? STRENGTH_MAX : mag[STR_W-1:0];
                    t.direction = (filt < 0) ? DIR_FALLING : DIR_RISING;
                    mode[ch]    = t.direction;
                    quiet[ch]   = '0;
                end
                else if (quiet[ch] < QUIET_MAX)
                begin
                    quiet[ch] = quiet[ch] + 1'b1;
                end
                t.filtered_slope = filt[SLOPE_W-1:0];
            end
            expected_q.push_back(t);
        endfunction

        function void check_result(logic [STR_W-1:0] s, logic [DIR_W-1:0] d,
                                   logic [SLOPE_W-1:0] f);
            trigger_t t;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, got strength %0d direction %0d slope %0d",
                         $time, s, d, $signed(f));
                return;
            end
            t = expected_q.pop_front();
            if (s !== t.strength || d !== t.direction || f !== t.filtered_slope)
            begin
                mismatches++;
                $display({"%0t: mismatch, expected strength %0d direction %0d slope %0d,",
                          " got strength %0d direction %0d slope %0d"},
                         $time, t.strength, t.direction, $signed(t.filtered_slope),
                         s, d, $signed(f));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, block under test
    // ------------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // cleared for one phase to get a stretch with no gaps or stalls
    bit                 idle_en = 1'b1;
    int unsigned        cycle_count = 0;
    int                 level [CHANNELS];

    slope_scoreboard sb = new();

    isad_in_if  sample_if ();
    isad_out_if result_if ();

    ir_slope_activation_detector #(
        .CHANNELS      (CHANNELS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_if),
        .result  (result_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    // gap or stall length: mostly none, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int clamp_reading(int v);
        if (v < 0)
            return 0;
        if (v > READ_MAX)
            return READ_MAX;
        return v;
    endfunction

    // present one request and hold it until the block takes it
    task automatic send_item(input int ch, input int rd);
        int gap;
        sample_if.channel <= CHAN_W'(ch);
        sample_if.reading <= READ_W'(rd);
        sample_if.valid   <= 1'b1;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
        gap = gap_len();
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and wait until every predicted result has been seen
    task automatic drain_results();
        sample_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        // every result is back, so the pipeline is empty; the extra wait is margin
        repeat (4) @(posedge clk);
    endtask

    // setup cycle, then access cycle until pready
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // random traffic made mostly of per-channel shapes: ramps that build up
    // real slopes, flat stretches that run the quiet counter past release,
    // hard jumps to the rails, and a share of plain noise
    task automatic run_bursts(input int n_items);
        int sent;
        int kind;
        int len;
        int step;
        int k;
        int ch;
        int other;
        sent = 0;
        while (sent < n_items)
        begin
            ch   = $urandom_range(0, CHANNELS - 1);
            kind = $urandom_range(0, 99);
            if (kind < 50)
            begin
                len  = $urandom_range(4, 30);
                step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, 400);
                if ($urandom_range(0, 1) == 1)
                    step = -step;
                for (k = 0; k < len; k++)
                begin
                    level[ch] = clamp_reading(level[ch] + step);
                    send_item(ch, level[ch]);
                    sent++;
                    // now and then another channel cuts in at its own level
                    if ($urandom_range(0, 4) == 0)
                    begin
                        other = $urandom_range(0, CHANNELS - 1);
                        send_item(other, level[other]);
                        sent++;
                    end
                end
            end
            else if (kind < 70)
            begin
                len = $urandom_range(1, 60);
                for (k = 0; k < len; k++)
                begin
                    send_item(ch, clamp_reading(level[ch] + int'($urandom_range(0, 6)) - 3));
                    sent++;
                end
            end
            else if (kind < 80)
            begin
                level[ch] = ($urandom_range(0, 1) == 1) ? READ_MAX : 0;
                send_item(ch, level[ch]);
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++)
                begin
                    send_item($urandom_range(0, CHANNELS - 1), $urandom_range(0, READ_MAX));
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // monitors: requests feed the predictor, results are checked in order
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && sample_if.valid && sample_if.ready)
            sb.note_request(sample_if.channel, sample_if.reading);
        if (rst_n && result_if.valid && result_if.ready)
            sb.check_result(result_if.strength, result_if.direction,
                            result_if.filtered_slope);
    end

    // result sink with random back-pressure
    initial
    begin
        int hold;
        hold = 0;
        result_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                result_if.ready <= 1'b0;
                hold--;
            end
            else
            begin
                result_if.ready <= 1'b1;
                hold = gap_len();
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int sens_plan[6];
        int p;
        sens_plan = '{0, 3, 1, 2, 3, 0};
        foreach (level[c]) level[c] = 0;

        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        sample_if.valid   <= 1'b0;
        sample_if.channel <= '0;
        sample_if.reading <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset sensitivity (cutoff 35, four slopes)
        send_item(7, READ_MAX);   // full-scale step, strength saturates
        send_item(7, 0);          // average still positive from the ring
        send_item(0, 0);          // zero slope never triggers
        send_item(3, 20);         // below the cutoff
        send_item(3, 140);        // just above the cutoff
        send_item(4, 140);        // exactly on the cutoff
        send_item(5, 139);        // one short of the cutoff
        send_item(1, 4095);
        send_item(2, 4096);
        send_item(6, 1);
        send_item(6, 8190);
        send_item(1, 0);
        send_item(7, 5461);
        send_item(2, 2730);

        // random phases, each opening with a sensitivity write while idle;
        // the drain before each write also pauses the sender until all is back
        for (p = 0; p < 6; p++)
        begin
            drain_results();
            apb_write(SENS_ADDR, sens_plan[p]);
            sb.set_sensitivity(sens_plan[p][SENS_W-1:0]);
            idle_en = (p != 2);
            run_bursts(PHASE_ITEMS);
        end

        drain_results();
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
